// ===== hw/rtl/ffla_pkg.sv =====
// Shared types and constants for the free-list slot index allocator.
package ffla_pkg;

   localparam int CMD_W     = 2;
   localparam int IDX_W     = 10;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 11;

   localparam logic [CNT_OUT_W-1:0] CAPACITY_RESET = 11'd1024;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK           = 2'd0,
      ST_FULL         = 2'd1,
      ST_NOTHING_LIVE = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } q_ctrl_type;

endpackage

// ===== hw/rtl/ffla_queue.sv =====
// Free index queue: circular memory with head prefetch and write bypass.
module ffla_queue #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ffla_pkg::q_ctrl_type                 ctrl,
   input  logic [ffla_pkg::IDX_W-1:0]           push_data,
   output logic [ffla_pkg::IDX_W-1:0]           head_data,
   output logic [$clog2(MAX_SLOTS+1)-1:0]       fill
);

   localparam int PTR_W = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS+1);

   logic [ffla_pkg::IDX_W-1:0] mem [MAX_SLOTS];
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [ffla_pkg::IDX_W-1:0] rd_ff;
   logic [ffla_pkg::IDX_W-1:0] byp_data_ff;
   logic                       byp_ff, byp_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(MAX_SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctrl.clear) begin
         head_in = '0;
         tail_in = '0;
         fill_in = '0;
      end else if (ctrl.pop) begin
         head_in = next_ptr(head_ff);
         fill_in = fill_ff - 1'b1;
      end else if (ctrl.push) begin
         tail_in = next_ptr(tail_ff);
         fill_in = fill_ff + 1'b1;
      end
      byp_in = ctrl.push && (tail_ff == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
         byp_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
         byp_ff  <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= push_data;
      end
      rd_ff       <= mem[head_in];
      byp_data_ff <= push_data;
   end

   assign head_data = byp_ff ? byp_data_ff : rd_ff;
   assign fill      = fill_ff;

endmodule

// ===== hw/rtl/fifo_free_list_index_allocator.sv =====
// Top level of the free-list slot index allocator with bump pointer.
//
// Usage: a command beat is taken at a rising edge with start high and busy low.
// busy is always low, so one command can be issued in every cycle.
// req_command selects allocate, free, pool reset or no operation;
// req_free_index is the index returned by a free. Each command gives exactly
// one result beat in the next cycle, with rsp_valid high for one cycle
// carrying rsp_slot_index, rsp_status and rsp_live_count. Throughput is one
// command per cycle, set by the single result register and the head prefetch
// of the free queue memory.
// Allocate reuses the oldest freed index, otherwise the next fresh index.
// The capacity register is written through csr_write_enable and csr_write_data,
// which the user must do only while no command is in flight; it is not enforced.
// Reset empties the queue, clears the counters and sets capacity to 1024;
// queue memory contents are not cleared. The receiver cannot stall: each
// result beat must be taken in the cycle it is shown.
module fifo_free_list_index_allocator #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ffla_pkg::CMD_W-1:0]          req_command,
   input  logic [ffla_pkg::IDX_W-1:0]          req_free_index,
   output logic                                rsp_valid,
   output logic [ffla_pkg::IDX_W-1:0]          rsp_slot_index,
   output logic [ffla_pkg::STAT_W-1:0]         rsp_status,
   output logic [ffla_pkg::CNT_OUT_W-1:0]      rsp_live_count,
   input  logic                                csr_write_enable,
   input  logic [ffla_pkg::CNT_OUT_W-1:0]      csr_write_data
);

   localparam int CNT_W = $clog2(MAX_SLOTS+1);
   localparam int CMP_W = (CNT_W > ffla_pkg::CNT_OUT_W) ? CNT_W : ffla_pkg::CNT_OUT_W;

   logic [ffla_pkg::CNT_OUT_W-1:0] capacity_ff;
   logic [CNT_W-1:0]               alloc_ff, alloc_in;
   logic [CNT_W-1:0]               fresh_ff, fresh_in;
   logic                           rsp_valid_ff;
   logic [ffla_pkg::IDX_W-1:0]     slot_ff, slot_in;
   logic [ffla_pkg::STAT_W-1:0]    status_ff, status_in;
   logic [ffla_pkg::CNT_OUT_W-1:0] live_ff;
   ffla_pkg::q_ctrl_type           q_ctrl;
   logic [ffla_pkg::IDX_W-1:0]     q_head_data;
   logic [CNT_W-1:0]               q_fill;
   logic [CMP_W-1:0]               cap_ext, cap_eff, alloc_ext;
   logic                           accept;

   ffla_queue #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (q_ctrl),
      .push_data (req_free_index),
      .head_data (q_head_data),
      .fill      (q_fill)
   );

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      cap_ext   = CMP_W'(capacity_ff);
      cap_eff   = (cap_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : cap_ext;
      alloc_ext = CMP_W'(alloc_ff);
      q_ctrl    = '0;
      slot_in   = '0;
      status_in = ffla_pkg::ST_OK;
      alloc_in  = alloc_ff;
      fresh_in  = fresh_ff;
      if (accept) begin
         case (ffla_pkg::cmd_type'(req_command))
            ffla_pkg::CMD_ALLOC: begin
               if (alloc_ext >= cap_eff) begin
                  status_in = ffla_pkg::ST_FULL;
               end else if (q_fill != '0) begin
                  slot_in    = q_head_data;
                  q_ctrl.pop = 1'b1;
                  alloc_in   = alloc_ff + 1'b1;
               end else if (CMP_W'(fresh_ff) >= CMP_W'(MAX_SLOTS)) begin
                  status_in = ffla_pkg::ST_FULL;
               end else begin
                  slot_in  = ffla_pkg::IDX_W'(fresh_ff);
                  fresh_in = fresh_ff + 1'b1;
                  alloc_in = alloc_ff + 1'b1;
               end
            end
            ffla_pkg::CMD_FREE: begin
               if (alloc_ff == '0 || CMP_W'(q_fill) >= CMP_W'(MAX_SLOTS)) begin
                  status_in = ffla_pkg::ST_NOTHING_LIVE;
               end else begin
                  q_ctrl.push = 1'b1;
                  alloc_in    = alloc_ff - 1'b1;
               end
            end
            ffla_pkg::CMD_RESET: begin
               q_ctrl.clear = 1'b1;
               alloc_in     = '0;
               fresh_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= ffla_pkg::CAPACITY_RESET;
         alloc_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         alloc_ff     <= alloc_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      status_ff <= status_in;
      live_ff   <= ffla_pkg::CNT_OUT_W'(alloc_in);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = slot_ff;
   assign rsp_status     = status_ff;
   assign rsp_live_count = live_ff;

   a_one_beat_per_command: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_valid)
      else $error("Command beat did not produce a result beat.");

   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      !start |=> !rsp_valid)
      else $error("Result beat without a command beat.");

   a_refused_gives_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ffla_pkg::ST_OK) |-> (rsp_slot_index == '0))
      else $error("Refused command returned a nonzero slot index.");

   a_live_bounded: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(alloc_ff) <= CMP_W'(MAX_SLOTS))
      else $error("Live count exceeds the pool size.");

   a_conservation: assert property (@(posedge clock) disable iff (reset)
      (CMP_W + 1)'(q_fill) + (CMP_W + 1)'(alloc_ff) == (CMP_W + 1)'(fresh_ff))
      else $error("Queued plus live slots differ from slots ever handed out.");

endmodule
